// File: hw/rtl/mrsf_pkg.sv
// ----------------------------------------------------------------------------
// mrsf_pkg
// Shared types and constants of the MIDI running status framer.
// ----------------------------------------------------------------------------
package mrsf_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] BYTE_META     = 8'hFF;
    localparam logic [7:0] BYTE_SYSEX    = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_CT = 8'hF7;
    localparam logic [7:0] BYTE_STATUS   = 8'h80;
    localparam logic [7:0] BYTE_ONE_LO   = 8'hC0;
    localparam logic [7:0] BYTE_ONE_HI   = 8'hDF;
    localparam logic [7:0] BYTE_CHAN_HI  = 8'hEF;

    localparam logic [1:0] RLEN_TWO   = 2'd2;
    localparam logic [1:0] RLEN_THREE = 2'd3;

    typedef enum logic [2:0] {
        KIND_CHANNEL = 3'd0,
        KIND_RUNNING = 3'd1,
        KIND_SYSEX   = 3'd2,
        KIND_META    = 3'd3,
        KIND_SYSTEM  = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_META_TYPE = 5'b00010,
        PH_LENGTH    = 5'b00100,
        PH_PAYLOAD   = 5'b01000,
        PH_DATA      = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       first;
        logic       last;
        kind_t      kind;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } slot_t;

endpackage

// File: hw/rtl/mrsf_front.sv
// ----------------------------------------------------------------------------
// mrsf_front
// Accepts stream bytes, tracks framing state and builds one queue slot of one
// or two results per byte.
// ----------------------------------------------------------------------------
module mrsf_front import mrsf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       q_full,
    output logic       push,
    output slot_t      push_slot
);

    phase_t     phase_reg, phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_status_reg, running_status_next;
    logic [1:0] running_length_reg, running_length_next;
    kind_t      current_kind_reg, current_kind_next;
    logic [7:0] dec_left;
    logic [7:0] b;

    assign b       = s_in_byte;
    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;
    assign dec_left = bytes_left_reg - 8'd1;

    always_comb begin
        phase_next          = phase_reg;
        bytes_left_next     = bytes_left_reg;
        running_status_next = running_status_reg;
        running_length_next = running_length_reg;
        current_kind_next   = current_kind_reg;
        push_slot           = '0;
        push_slot.r0.out_byte = b;
        push_slot.r0.kind     = current_kind_reg;
        case (phase_reg)
            PH_META_TYPE: begin
                phase_next = PH_LENGTH;
            end
            PH_LENGTH: begin
                bytes_left_next = b;
                phase_next      = (b == 8'd0) ? PH_IDLE : PH_PAYLOAD;
                push_slot.r0.last = (b == 8'd0);
            end
            PH_PAYLOAD, PH_DATA: begin
                bytes_left_next = dec_left;
                if (dec_left == 8'd0) begin
                    phase_next = PH_IDLE;
                end
                push_slot.r0.last = (dec_left == 8'd0);
            end
            default: begin
                phase_next         = PH_IDLE;
                push_slot.r0.first = 1'b1;
                if (b == BYTE_META) begin
                    current_kind_next = KIND_META;
                    phase_next        = PH_META_TYPE;
                end else if (b == BYTE_SYSEX || b == BYTE_SYSEX_CT) begin
                    current_kind_next = KIND_SYSEX;
                    phase_next        = PH_LENGTH;
                end else if (b < BYTE_STATUS) begin
                    current_kind_next      = KIND_RUNNING;
                    push_slot.two          = 1'b1;
                    push_slot.r0.out_byte  = running_status_reg;
                    push_slot.r1.out_byte  = b;
                    push_slot.r1.kind      = KIND_RUNNING;
                    push_slot.r1.last      = (running_length_reg != RLEN_THREE);
                    if (running_length_reg == RLEN_THREE) begin
                        bytes_left_next = 8'd1;
                        phase_next      = PH_DATA;
                    end
                end else if (b >= BYTE_ONE_LO && b <= BYTE_ONE_HI) begin
                    running_status_next = b;
                    running_length_next = RLEN_TWO;
                    bytes_left_next     = 8'd1;
                    current_kind_next   = KIND_CHANNEL;
                    phase_next          = PH_DATA;
                end else if (b <= BYTE_CHAN_HI) begin
                    running_status_next = b;
                    running_length_next = RLEN_THREE;
                    bytes_left_next     = 8'd2;
                    current_kind_next   = KIND_CHANNEL;
                    phase_next          = PH_DATA;
                end else begin
                    current_kind_next = KIND_SYSTEM;
                    push_slot.r0.last = 1'b1;
                end
                push_slot.r0.kind = current_kind_next;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            bytes_left_reg     <= '0;
            running_status_reg <= '0;
            running_length_reg <= '0;
            current_kind_reg   <= KIND_CHANNEL;
        end else if (push) begin
            phase_reg          <= phase_next;
            bytes_left_reg     <= bytes_left_next;
            running_status_reg <= running_status_next;
            running_length_reg <= running_length_next;
            current_kind_reg   <= current_kind_next;
        end
    end

endmodule

// File: hw/rtl/mrsf_queue.sv
// ----------------------------------------------------------------------------
// mrsf_queue
// Short slot queue between the front and the back.
// ----------------------------------------------------------------------------
module mrsf_queue import mrsf_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  slot_t push_slot,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output slot_t head_slot
);

    slot_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg, count_next;

    assign full       = (count_reg == (QAW+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_slot  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/mrsf_back.sv
// ----------------------------------------------------------------------------
// mrsf_back
// Drains queue slots onto the result channel, one result per transaction.
// ----------------------------------------------------------------------------
module mrsf_back import mrsf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  slot_t      head_slot,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_first_of_message,
    output logic       m_last_of_message,
    output logic [2:0] m_message_kind
);

    logic    sub_reg;
    result_t cur;
    logic    xfer;

    assign cur     = sub_reg ? head_slot.r1 : head_slot.r0;
    assign m_valid = head_valid;
    assign xfer    = head_valid && m_ready;
    assign pop     = xfer && (sub_reg || !head_slot.two);

    assign m_out_byte         = cur.out_byte;
    assign m_first_of_message = cur.first;
    assign m_last_of_message  = cur.last;
    assign m_message_kind     = cur.kind;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg <= 1'b0;
        end else if (xfer) begin
            sub_reg <= head_slot.two && !sub_reg;
        end
    end

endmodule

// File: hw/rtl/midi_running_status_framer.sv
// ----------------------------------------------------------------------------
// midi_running_status_framer
// Frames a MIDI byte stream into messages with kind and first/last flags,
// re-emitting the running status before bare data bytes.
//
// Channel   Dir  Ports                                   Transaction
// s_        in   s_valid s_ready s_in_byte               one stream byte
// m_        out  m_valid m_ready m_out_byte m_first_of_message
//                m_last_of_message m_message_kind        one framed byte
//
// One input byte per cycle while the queue is not full; its first result is offered
// on m_ once its slot, written into the queue, reaches the queue head.
// A running-status byte yields two output transactions, so the output port (one
// result per cycle while m_ready is high) sets the sustained rate for such streams.
// Synchronous active-low reset; the four-slot queue lets s_ and m_ stall
// independently; s_ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module midi_running_status_framer import mrsf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_first_of_message,
    output logic       m_last_of_message,
    output logic [2:0] m_message_kind
);

    logic  push;
    slot_t push_slot;
    logic  q_full;
    logic  pop;
    logic  head_valid;
    slot_t head_slot;

    mrsf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_full),
        .push      (push),
        .push_slot (push_slot)
    );

    mrsf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_slot  (push_slot),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_slot  (head_slot)
    );

    mrsf_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .head_valid         (head_valid),
        .head_slot          (head_slot),
        .pop                (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_byte         (m_out_byte),
        .m_first_of_message (m_first_of_message),
        .m_last_of_message  (m_last_of_message),
        .m_message_kind     (m_message_kind)
    );

endmodule
